/* rtl/b2da_pkg.sv */
// shared constants and conversion helpers for the binary to decimal ascii block
// no dependencies
`default_nettype none

package b2da_pkg;

  localparam int VAL_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIG_W      = 4;
  localparam int BCD_W      = NUM_DIGITS * DIG_W;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int CHAR_W     = 6;
  localparam int STEP_BITS  = 8;
  localparam int NUM_STAGES = VAL_W / STEP_BITS;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
  localparam logic [DIG_W-1:0]  DAB_LIMIT  = DIG_W'(5);
  localparam logic [DIG_W-1:0]  DAB_ADJ    = DIG_W'(3);

  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [VAL_W-1:0] bin_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    bcd_t bcd;
    bin_t bin;
  } dab_t;

  // eight shift-and-add-3 steps of double dabble
  function automatic dab_t dabble_steps(input bcd_t bcd_in, input bin_t bin_in);
    bcd_t bcd;
    bin_t bin;
    dab_t res;
    bcd = bcd_in;
    bin = bin_in;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd[d*DIG_W +: DIG_W] >= DAB_LIMIT) begin
          bcd[d*DIG_W +: DIG_W] = bcd[d*DIG_W +: DIG_W] + DAB_ADJ;
        end
      end
      bcd = {bcd[BCD_W-2:0], bin[VAL_W-1]};
      bin = {bin[VAL_W-2:0], 1'b0};
    end
    res.bcd = bcd;
    res.bin = bin;
    return res;
  endfunction

  // position of the most significant nonzero digit, zero for a zero value
  function automatic idx_t msd_index(input bcd_t bcd);
    idx_t pos;
    pos = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[d*DIG_W +: DIG_W] != '0) begin
        pos = IDX_W'(d);
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

/* rtl/binary_to_decimal_ascii_top.sv */
// binary to decimal ascii converter: double dabble pipeline and digit serializer
// depends on b2da_pkg
//
// path: a value passes the input register, four 8-bit dabble stages and the
//   serializer load before its first character is on the outputs
// throughput: one character word per cycle while out_stall is low; a value with
//   n digits (1 to 10) gives n words, a run ready at the pipe end follows with no gap
// reset: rst (synchronous, active high) clears all valid bits and the serializer
`default_nettype none

module binary_to_decimal_ascii_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic [b2da_pkg::VAL_W-1:0]   value,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [b2da_pkg::CHAR_W-1:0]  digit_char,
  output      logic                         last_digit
);

  import b2da_pkg::*;

  // stage 0 is the input register, stages 1..NUM_STAGES each retire 8 bits
  logic stg_vld [0:NUM_STAGES];
  bcd_t stg_bcd [0:NUM_STAGES];
  bin_t stg_bin [0:NUM_STAGES];
  logic stg_rdy [0:NUM_STAGES];
  dab_t stg_dab [1:NUM_STAGES];

  // serializer: full bcd word of the current run and index of the digit shown
  logic busy;
  bcd_t sr_bcd;
  idx_t sr_idx;
  logic load;
  logic [DIG_W-1:0] cur_dig;

  // a new run loads when nothing is shown or the last digit is leaving
  assign load = !busy || (sr_idx == '0 && !out_stall);

  // each stage moves when it is empty or the stage after it moves
  always_comb begin
    stg_rdy[NUM_STAGES] = !stg_vld[NUM_STAGES] || load;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      stg_rdy[k] = !stg_vld[k] || stg_rdy[k+1];
    end
  end

  always_comb begin
    for (int k = 1; k <= NUM_STAGES; k++) begin
      stg_dab[k] = dabble_steps(stg_bcd[k-1], stg_bin[k-1]);
    end
  end

  assign in_stall = !stg_rdy[0];

  // input register and double dabble stages, valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_vld[0] <= 1'b0;
    end else if (stg_rdy[0]) begin
      stg_vld[0] <= in_valid;
    end
    if (stg_rdy[0] && in_valid) begin
      stg_bcd[0] <= '0;
      stg_bin[0] <= value;
    end
    for (int k = 1; k <= NUM_STAGES; k++) begin
      if (rst) begin
        stg_vld[k] <= 1'b0;
      end else if (stg_rdy[k]) begin
        stg_vld[k] <= stg_vld[k-1];
      end
      if (stg_rdy[k] && stg_vld[k-1]) begin
        stg_bcd[k] <= stg_dab[k].bcd;
        stg_bin[k] <= stg_dab[k].bin;
      end
    end
  end

  // serializer: walks from the leading nonzero digit down to the units digit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      sr_idx <= '0;
    end else if (load) begin
      busy <= stg_vld[NUM_STAGES];
      if (stg_vld[NUM_STAGES]) begin
        sr_bcd <= stg_bcd[NUM_STAGES];
        sr_idx <= msd_index(stg_bcd[NUM_STAGES]);
      end
    end else if (!out_stall) begin
      sr_idx <= sr_idx - 1'b1;
    end
  end

  assign cur_dig    = sr_bcd[sr_idx*DIG_W +: DIG_W];
  assign out_valid  = busy;
  assign digit_char = ASCII_ZERO + CHAR_W'(cur_dig);
  assign last_digit = (sr_idx == '0);

  // a stalled input always has a word sitting in the input register
  a_stall_has_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> stg_vld[0])
    else $error("input stall with empty input register");

  // the dabble pipeline never leaves a digit above nine
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cur_dig <= DIG_W'(9)))
    else $error("bcd digit out of range");

  // a finished conversion at the pipe end starts a run in the next cycle
  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    (load && stg_vld[NUM_STAGES]) |=> out_valid)
    else $error("loaded run did not show a word");

  // a run never opens with a leading zero unless it is the single zero digit
  a_no_lead_zero: assert property (@(posedge clk) disable iff (rst)
    (load && stg_vld[NUM_STAGES]) |=> (cur_dig != '0 || last_digit))
    else $error("run opened with a leading zero");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for binary_to_decimal_ascii_top
// predicts the decimal digit words of every accepted value and compares them in order
// depends on b2da_pkg and binary_to_decimal_ascii_top
`timescale 1ns / 100ps

module testbench;

  import b2da_pkg::*;

  localparam int RADIX       = 10;
  localparam int MAX_CHARS   = 10;
  localparam int CYCLE_LIMIT = 250000;
  localparam int REPORT_MAX  = 10;
  localparam int DRAIN_WAIT  = 24;
  localparam int PHASE_COUNT = 4;
  localparam int PHASE_ITEMS = 32;

  // one output word: a digit character and the end-of-run mark
  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_word_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [VAL_W-1:0]  value     = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CHAR_W-1:0] digit_char;
  logic              last_digit;

  bin_t       pending_values[$];
  char_word_t expected_words[$];

  // idle bounds for the sender gap and the receiver stall, changed per phase
  int in_gap_max    = 10;
  int out_stall_max = 10;

  int gap_left   = 0;
  int stall_left = 0;
  int errors     = 0;
  int cycle_cnt  = 0;

  binary_to_decimal_ascii_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  always #2 clk = ~clk;

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // expected words for one value: peel decimal digits off the low end,
  // then queue them most significant first, marking the units digit
  task automatic queue_digit_words(input bin_t num);
    logic [3:0] digits[MAX_CHARS];
    bin_t       rest;
    int         n;
    char_word_t w;
    rest = num;
    n = 0;
    // zero still yields one '0' digit, hence do-while
    do begin
      digits[n] = 4'(rest % RADIX);
      rest = rest / RADIX;
      n++;
    end while (rest != '0 && n < MAX_CHARS);
    for (int k = n - 1; k >= 0; k--) begin
      w.ch   = ASCII_ZERO + CHAR_W'(digits[k]);
      w.last = (k == 0);
      expected_words.push_back(w);
    end
  endtask

  // sender: presents values from the pending queue, holds them while stalled,
  // and waits a random number of cycles after each accepted word
  always @(posedge clk) begin : drive_values
    int wait_n;
    if (rst) begin
      in_valid <= 1'b0;
      value    <= '0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      wait_n = gap_left;
      if (in_valid) begin
        // accepted at this edge
        queue_digit_words(value);
        wait_n = $urandom_range(in_gap_max);
      end
      if (wait_n > 0) begin
        in_valid <= 1'b0;
        gap_left <= wait_n - 1;
      end else if (pending_values.size() > 0) begin
        in_valid <= 1'b1;
        value    <= pending_values.pop_front();
        gap_left <= 0;
      end else begin
        in_valid <= 1'b0;
        gap_left <= 0;
      end
    end
  end

  // receiver: checks each accepted word against the oldest expectation,
  // then stalls for a random number of cycles
  always @(posedge clk) begin : check_words
    char_word_t want;
    int         n;
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        if (errors < REPORT_MAX) begin
          $display("unexpected word: char %0d last %0b", digit_char, last_digit);
        end
        errors <= errors + 1;
      end else begin
        want = expected_words.pop_front();
        if (digit_char !== want.ch || last_digit !== want.last) begin
          if (errors < REPORT_MAX) begin
            $display("word mismatch: char exp %0d got %0d, last exp %0b got %0b",
                     want.ch, digit_char, want.last, last_digit);
          end
          errors <= errors + 1;
        end
      end
      n = $urandom_range(out_stall_max);
      out_stall  <= (n > 0);
      stall_left <= (n > 0) ? n - 1 : 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // stimulus and end of run
  initial begin
    int          gap_set[PHASE_COUNT];
    int          stall_set[PHASE_COUNT];
    int          ndig;
    longint      lo;
    longint      hi;
    bin_t        v;

    // phases: idling on both sides, none at all, sender only, receiver only
    gap_set   = '{10, 0, 10, 0};
    stall_set = '{10, 0, 0, 10};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: zero, extremes, every digit, digit count boundaries at 10, 100, 10^9
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(32'd99);
    pending_values.push_back(32'd100);
    pending_values.push_back(32'd1234567890);
    pending_values.push_back(32'd987654321);
    pending_values.push_back(32'd999999999);
    pending_values.push_back(32'd1000000000);
    pending_values.push_back(32'd4294967295);
    pending_values.push_back(32'd4294967294);
    pending_values.push_back(32'd4294967290);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'h5555_5555);
    pending_values.push_back(32'hAAAA_AAAA);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd10000);
    pending_values.push_back(32'd99999);
    pending_values.push_back(32'd3999999999);
    pending_values.push_back(32'd1000000001);
    pending_values.push_back(32'd5);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // let the sender take the previous items before the idle bounds change
      @(negedge clk);
      while (pending_values.size() > 0) @(negedge clk);
      in_gap_max    = gap_set[p];
      out_stall_max = stall_set[p];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(3) == 0) begin
          // full-range value, exercises every input bit
          v = $urandom;
        end else begin
          // uniform digit count first, so short runs are as common as long ones
          ndig = $urandom_range(MAX_CHARS, 1);
          lo = 1;
          for (int d = 1; d < ndig; d++) lo = lo * RADIX;
          hi = lo * RADIX - 1;
          if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
          if (ndig == 1) lo = 0;
          v = VAL_W'(lo + $urandom_range(32'(hi - lo)));
        end
        pending_values.push_back(v);
      end
    end

    // all values accepted, then all words back, then a quiet tail
    @(negedge clk);
    while (pending_values.size() > 0 || in_valid) @(negedge clk);
    while (expected_words.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (expected_words.size() != 0 || errors != 0) begin
      $display("testbench: errors");
    end else begin
      $display("testbench: clean");
    end
    $finish;
  end

endmodule
